/* sv/iepc_pkg.sv */
`timescale 1ns / 1ps
// Package: shared types and constants of the ICMP error / UDP probe classifier.
package iepc_pkg;

    // Packet length limit and the width that holds any supported limit
    localparam int MAX_PACKET_BYTES_DEF = 4096;
    localparam int LEN_W                = 13;

    // Depth of the queue between the byte parser and the verdict stage
    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Configuration register indexes
    localparam logic CFG_SRC_PORT = 1'b0;
    localparam logic CFG_DST_PORT = 1'b1;
    localparam logic [15:0] SRC_PORT_RST = 16'd32768;
    localparam logic [15:0] DST_PORT_RST = 16'd33434;

    // Header offsets and sizes
    localparam logic [LEN_W-1:0] IP_PROTO_OFS = LEN_W'(9);
    localparam logic [LEN_W-1:0] ICMP_HDR_LEN = LEN_W'(8);
    localparam logic [LEN_W-1:0] UDP_HDR_LEN  = LEN_W'(8);
    localparam logic [5:0]       MIN_IP_HDR   = 6'd20;

    // Protocol numbers
    localparam logic [7:0] PROTO_ICMP = 8'd1;
    localparam logic [7:0] PROTO_UDP  = 8'd17;

    // ICMP types and codes
    localparam logic [7:0] ICMP_TIME_EXCEEDED = 8'd11;
    localparam logic [7:0] ICMP_DEST_UNREACH  = 8'd3;
    localparam logic [7:0] CODE_TTL_EXPIRED   = 8'd0;
    localparam logic [7:0] CODE_PORT_UNREACH  = 8'd3;
    localparam logic [7:0] CODE_SRC_ROUTE     = 8'd5;

    typedef enum logic [1:0] {
        VERDICT_NONE          = 2'd0,
        VERDICT_TIME_EXCEEDED = 2'd1,
        VERDICT_PORT_UNREACH  = 2'd2,
        VERDICT_SRC_ROUTE     = 2'd3
    } verdict_t;

    // Fields captured from one packet, handed from parser to verdict stage
    typedef struct packed {
        logic [LEN_W-1:0] len;
        logic [5:0]       ohl;
        logic             outer_icmp;
        logic [7:0]       kind;
        logic [7:0]       subcode;
        logic [5:0]       ihl;
        logic             inner_udp;
        logic [15:0]      src_port;
        logic [15:0]      dst_port;
    } iepc_summary_t;

endpackage

/* sv/iepc_front.sv */
`timescale 1ns / 1ps
// Byte parser: counts packet bytes and captures header fields by offset.
module iepc_front #(
    parameter int MAX_PACKET_BYTES = iepc_pkg::MAX_PACKET_BYTES_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_stall,
    input  logic [7:0]            data_byte,
    input  logic                  last_byte,
    output logic                  push,
    output iepc_pkg::iepc_summary_t summary
);
    import iepc_pkg::*;

    localparam int CNT_W = $clog2(MAX_PACKET_BYTES + 1);

    logic [CNT_W-1:0] byte_count_reg, byte_count_next;
    logic [5:0]       ohl_reg, ohl_next;
    logic             outer_icmp_reg, outer_icmp_next;
    logic [7:0]       kind_reg, kind_next;
    logic [7:0]       subcode_reg, subcode_next;
    logic [5:0]       ihl_reg, ihl_next;
    logic             inner_udp_reg, inner_udp_next;
    logic [15:0]      src_reg, src_next;
    logic [15:0]      dst_reg, dst_next;

    logic             accept;
    logic             in_range;
    logic             first;
    logic [LEN_W-1:0] pos;
    logic [LEN_W-1:0] ohl_x;
    logic [LEN_W-1:0] udp_at;

    assign accept = in_valid && !in_stall;

    // Capture fields at their offsets; the first byte restarts the packet
    always_comb
    begin
        pos      = LEN_W'(byte_count_reg);
        in_range = byte_count_reg < CNT_W'(MAX_PACKET_BYTES);
        first    = (byte_count_reg == '0);

        ohl_next        = ohl_reg;
        outer_icmp_next = outer_icmp_reg;
        kind_next       = kind_reg;
        subcode_next    = subcode_reg;
        ihl_next        = ihl_reg;
        inner_udp_next  = inner_udp_reg;
        src_next        = src_reg;
        dst_next        = dst_reg;
        byte_count_next = byte_count_reg;

        if (first)
        begin
            ohl_next        = {data_byte[3:0], 2'b00};
            outer_icmp_next = 1'b0;
            kind_next       = '0;
            subcode_next    = '0;
            ihl_next        = '0;
            inner_udp_next  = 1'b0;
            src_next        = '0;
            dst_next        = '0;
        end

        ohl_x = LEN_W'(ohl_next);

        if (in_range)
        begin
            byte_count_next = byte_count_reg + CNT_W'(1);
            if (pos == IP_PROTO_OFS)
                outer_icmp_next = (data_byte == PROTO_ICMP);
            if (pos == ohl_x)
                kind_next = data_byte;
            if (pos == ohl_x + LEN_W'(1))
                subcode_next = data_byte;
            if (pos == ohl_x + ICMP_HDR_LEN)
                ihl_next = {data_byte[3:0], 2'b00};
            if (pos == ohl_x + ICMP_HDR_LEN + IP_PROTO_OFS)
                inner_udp_next = (data_byte == PROTO_UDP);
        end

        udp_at = ohl_x + ICMP_HDR_LEN + LEN_W'(ihl_next);

        if (in_range)
        begin
            if (pos == udp_at)
                src_next[15:8] = data_byte;
            if (pos == udp_at + LEN_W'(1))
                src_next[7:0] = data_byte;
            if (pos == udp_at + LEN_W'(2))
                dst_next[15:8] = data_byte;
            if (pos == udp_at + LEN_W'(3))
                dst_next[7:0] = data_byte;
        end
    end

    // Hand the packet summary to the queue on the last word
    assign push = accept && last_byte;

    always_comb
    begin
        summary.len        = LEN_W'(byte_count_next);
        summary.ohl        = ohl_next;
        summary.outer_icmp = outer_icmp_next;
        summary.kind       = kind_next;
        summary.subcode    = subcode_next;
        summary.ihl        = ihl_next;
        summary.inner_udp  = inner_udp_next;
        summary.src_port   = src_next;
        summary.dst_port   = dst_next;
    end

    // Advance the byte counter; wrap to zero after the last word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            byte_count_reg <= '0;
        else if (accept)
            byte_count_reg <= last_byte ? '0 : byte_count_next;
    end

    // Hold captured fields
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ohl_reg        <= ohl_next;
            outer_icmp_reg <= outer_icmp_next;
            kind_reg       <= kind_next;
            subcode_reg    <= subcode_next;
            ihl_reg        <= ihl_next;
            inner_udp_reg  <= inner_udp_next;
            src_reg        <= src_next;
            dst_reg        <= dst_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        byte_count_reg <= CNT_W'(MAX_PACKET_BYTES))
        else $error("byte counter ran past the packet limit");

endmodule

/* sv/iepc_queue.sv */
`timescale 1ns / 1ps
// Short queue of packet summaries between the parser and the verdict stage.
module iepc_queue (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  iepc_pkg::iepc_summary_t push_data,
    input  logic                    pop,
    output logic                    full,
    output logic                    not_empty,
    output iepc_pkg::iepc_summary_t head
);
    import iepc_pkg::*;

    iepc_summary_t     entry_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == QCNT_W'(QDEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = entry_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + QPTR_W'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + QPTR_W'(1);
        count_next = count_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the incoming summary
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!full || pop))
        else $error("summary pushed into a full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("summary popped from an empty queue");

endmodule

/* sv/iepc_back.sv */
`timescale 1ns / 1ps
// Verdict stage: holds probe ports, judges one summary and registers the result.
module iepc_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic                    cfg_index,
    input  logic [15:0]             cfg_data,
    input  logic                    head_valid,
    input  iepc_pkg::iepc_summary_t head,
    output logic                    pop,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [1:0]              verdict
);
    import iepc_pkg::*;

    logic [15:0]      src_port_reg;
    logic [15:0]      dst_port_reg;
    logic             out_valid_reg, out_valid_next;
    verdict_t         verdict_reg, verdict_next;
    logic [LEN_W-1:0] min_len_fixed;
    logic [LEN_W-1:0] min_len_inner;
    logic             frame_ok;

    // Write probe ports
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_port_reg <= SRC_PORT_RST;
            dst_port_reg <= DST_PORT_RST;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_SRC_PORT)
                src_port_reg <= cfg_data;
            if (cfg_index == CFG_DST_PORT)
                dst_port_reg <= cfg_data;
        end
    end

    // Take a summary when the output register is free or being drained
    assign pop = head_valid && (!out_valid_reg || !out_stall);

    // Judge lengths, protocols, ports, then the ICMP type and code
    always_comb
    begin
        min_len_fixed = LEN_W'(head.ohl) + ICMP_HDR_LEN + LEN_W'(MIN_IP_HDR);
        min_len_inner = LEN_W'(head.ohl) + ICMP_HDR_LEN + LEN_W'(head.ihl) + UDP_HDR_LEN;
        frame_ok = head.outer_icmp && (head.ohl >= MIN_IP_HDR)
                && (head.len >= min_len_fixed) && (head.len >= min_len_inner)
                && head.inner_udp
                && (head.src_port == src_port_reg) && (head.dst_port == dst_port_reg);

        verdict_next = VERDICT_NONE;
        if (frame_ok)
        begin
            if (head.kind == ICMP_TIME_EXCEEDED && head.subcode == CODE_TTL_EXPIRED)
                verdict_next = VERDICT_TIME_EXCEEDED;
            else if (head.kind == ICMP_DEST_UNREACH && head.subcode == CODE_PORT_UNREACH)
                verdict_next = VERDICT_PORT_UNREACH;
            else if (head.kind == ICMP_DEST_UNREACH && head.subcode == CODE_SRC_ROUTE)
                verdict_next = VERDICT_SRC_ROUTE;
        end

        if (pop)
            out_valid_next = 1'b1;
        else if (out_stall)
            out_valid_next = out_valid_reg;
        else
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            verdict_reg <= verdict_next;
    end

    assign out_valid = out_valid_reg;
    assign verdict   = verdict_reg;

    a_valid_from_pop: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(pop))
        else $error("output word appeared without a summary being taken");

endmodule

/* sv/icmp_error_udp_probe_classifier_top.sv */
`timescale 1ns / 1ps
// Top level of the ICMP error / UDP probe reply classifier.
//
// Input channel: one packet byte per word (data_byte, last_byte), starting at
// the outer IPv4 header; accepted when in_valid is high and in_stall is low.
// Output channel: one verdict word per packet, given for its last byte; taken
// when out_valid is high and out_stall is low. Verdict codes: 0 none,
// 1 time exceeded, 2 port unreachable, 3 source route failed.
// Configuration: cfg_we writes cfg_data to probe source port (index 0) or
// probe destination port (index 1); write only while no packet is pending.
// Throughput: one byte per cycle; the byte parser captures header fields by
// offset compare and waits on the verdict stage only when the queue is full.
// Output path: the edge that accepts the last byte writes its summary into the queue;
// the verdict register then loads it from the queue head once it is free or draining.
// Stall: the two-entry summary queue absorbs packets while out_stall is high;
// in_stall rises only when the queue is full.
// Reset: byte counter and queue clear, probe ports return to 32768 and 33434.
module icmp_error_udp_probe_classifier_top #(
    parameter int MAX_PACKET_BYTES = iepc_pkg::MAX_PACKET_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  verdict,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);
    import iepc_pkg::*;

    iepc_summary_t front_summary;
    iepc_summary_t queue_head;
    logic          push;
    logic          pop;
    logic          queue_full;
    logic          queue_not_empty;

    assign in_stall = queue_full;

    iepc_front #(
        .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (queue_full),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .push      (push),
        .summary   (front_summary)
    );

    iepc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (front_summary),
        .pop       (pop),
        .full      (queue_full),
        .not_empty (queue_not_empty),
        .head      (queue_head)
    );

    iepc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .head_valid (queue_not_empty),
        .head       (queue_head),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .verdict    (verdict)
    );

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps
// Testbench: packet byte streams in, every verdict checked against a local classifier.
module testbench;
    import iepc_pkg::*;

    localparam int MAX_BYTES     = MAX_PACKET_BYTES_DEF;
    localparam int IDLE_PCT      = 18;
    localparam int DRAIN_CYCLES  = 4;
    localparam int HOLD_CYCLES   = 400;
    localparam int RANDOM_BYTES  = 200;
    localparam int RANDOM_FRAMES = 4;
    localparam int PHASE_BYTES   = 60;

    typedef struct packed {
        logic [7:0] data;
        logic       is_last;
    } pkt_byte_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  data_byte = 8'h00;
    logic        last_byte = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  verdict;
    logic        cfg_we = 1'b0;
    logic        cfg_index = CFG_SRC_PORT;
    logic [15:0] cfg_data = 16'h0000;

    // Words waiting to be sent, verdicts waiting to come out
    pkt_byte_t   packet_bytes [$];
    verdict_t    pending_verdicts [$];
    logic [7:0]  frame [$];

    logic        word_taken = 1'b0;
    int          send_idle_pct = IDLE_PCT;
    int          recv_idle_pct = IDLE_PCT;
    int          holds_asked = 0;
    int          holds_served = 0;
    int          hold_left = 0;
    int          fail_count = 0;
    int          rand_bytes = 0;
    int          rand_frames = 0;

    // Classifier copy: probe ports and the fields captured from the current packet
    logic [15:0]      cfg_src_port = SRC_PORT_RST;
    logic [15:0]      cfg_dst_port = DST_PORT_RST;
    logic [LEN_W-1:0] rx_len = '0;
    logic [5:0]       rx_ohl = '0;
    logic [5:0]       rx_ihl = '0;
    logic             rx_icmp = 1'b0;
    logic             rx_udp = 1'b0;
    logic [7:0]       rx_kind = '0;
    logic [7:0]       rx_code = '0;
    logic [15:0]      rx_src = '0;
    logic [15:0]      rx_dst = '0;

    icmp_error_udp_probe_classifier_top #(
        .MAX_PACKET_BYTES(MAX_BYTES)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .verdict   (verdict),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Verdict for the packet just closed, from the captured fields
    function automatic verdict_t judge_packet(input logic [LEN_W-1:0] len);
        int ohl;
        ohl = rx_ohl;
        if (!rx_icmp || rx_ohl < MIN_IP_HDR)
            return VERDICT_NONE;
        if (int'(len) < ohl + ICMP_HDR_LEN + MIN_IP_HDR)
            return VERDICT_NONE;
        if (int'(len) < ohl + ICMP_HDR_LEN + rx_ihl + UDP_HDR_LEN)
            return VERDICT_NONE;
        if (!rx_udp || rx_src != cfg_src_port || rx_dst != cfg_dst_port)
            return VERDICT_NONE;
        if (rx_kind == ICMP_TIME_EXCEEDED && rx_code == CODE_TTL_EXPIRED)
            return VERDICT_TIME_EXCEEDED;
        if (rx_kind == ICMP_DEST_UNREACH && rx_code == CODE_PORT_UNREACH)
            return VERDICT_PORT_UNREACH;
        if (rx_kind == ICMP_DEST_UNREACH && rx_code == CODE_SRC_ROUTE)
            return VERDICT_SRC_ROUTE;
        return VERDICT_NONE;
    endfunction

    // Capture one accepted byte by offset; on the last byte queue the verdict
    task automatic parse_byte(input logic [7:0] b, input logic is_last);
        int pos;
        int ohl;
        int udp_at;
        pos = rx_len;
        if (pos < MAX_BYTES)
        begin
            if (pos == 0)
            begin
                rx_ihl  = '0;
                rx_icmp = 1'b0;
                rx_udp  = 1'b0;
                rx_kind = '0;
                rx_code = '0;
                rx_src  = '0;
                rx_dst  = '0;
                rx_ohl  = {b[3:0], 2'b00};
            end
            ohl = rx_ohl;
            if (pos == IP_PROTO_OFS)
                rx_icmp = (b == PROTO_ICMP);
            if (pos == ohl)
                rx_kind = b;
            if (pos == ohl + 1)
                rx_code = b;
            if (pos == ohl + ICMP_HDR_LEN)
                rx_ihl = {b[3:0], 2'b00};
            if (pos == ohl + ICMP_HDR_LEN + IP_PROTO_OFS)
                rx_udp = (b == PROTO_UDP);
            // UDP ports sit behind the embedded header, overlap or not
            udp_at = ohl + ICMP_HDR_LEN + rx_ihl;
            if (pos == udp_at)
                rx_src[15:8] = b;
            if (pos == udp_at + 1)
                rx_src[7:0] = b;
            if (pos == udp_at + 2)
                rx_dst[15:8] = b;
            if (pos == udp_at + 3)
                rx_dst[7:0] = b;
            rx_len = LEN_W'(pos + 1);
        end
        if (is_last)
        begin
            pending_verdicts.push_back(judge_packet(rx_len));
            rx_len = '0;
        end
    endtask

    // Sender: hold a stalled word, otherwise advance or idle
    always @(negedge clk)
    begin : drive_bytes
        pkt_byte_t w;
        if (in_valid && !word_taken)
        begin
        end
        else if (rst_n && packet_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct)
        begin
            w = packet_bytes.pop_front();
            data_byte <= w.data;
            last_byte <= w.is_last;
            in_valid  <= 1'b1;
        end
        else
        begin
            in_valid <= 1'b0;
        end
    end

    // Receiver: random stalls, plus a long hold when one is asked for
    always @(negedge clk)
    begin : drive_stall
        if (hold_left != 0)
        begin
            hold_left = hold_left - 1;
            out_stall <= 1'b1;
        end
        else if (holds_served != holds_asked)
        begin
            holds_served = holds_served + 1;
            hold_left = HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Monitor: predict on every accepted byte, check every accepted verdict
    always @(posedge clk)
    begin : watch
        verdict_t want;
        if (rst_n)
        begin
            word_taken <= in_valid && !in_stall;
            if (out_valid && !out_stall)
            begin
                if (pending_verdicts.size() == 0)
                begin
                    $display("%0t: verdict %0d with none expected, expected none", $time,
                             verdict);
                    fail_count = fail_count + 1;
                end
                else
                begin
                    want = pending_verdicts.pop_front();
                    if (verdict !== want)
                    begin
                        $display("%0t: verdict expected %0d, actual %0d", $time, want,
                                 verdict);
                        fail_count = fail_count + 1;
                    end
                end
            end
            if (in_valid && !in_stall)
                parse_byte(data_byte, last_byte);
        end
    end

    // Lay down a probe reply: outer header, ICMP header, embedded header, UDP ports
    task automatic build_reply(input int oihl, input int iihl, input logic [7:0] kind,
                               input logic [7:0] code, input logic [15:0] src,
                               input logic [15:0] dst, input int pad);
        int olen;
        int udp_at;
        int total;
        olen   = oihl * 4;
        udp_at = olen + ICMP_HDR_LEN + iihl * 4;
        total  = (olen + 28 > udp_at + 8) ? olen + 28 : udp_at + 8;
        total  = total + pad;
        frame.delete();
        for (int i = 0; i < total; i++)
            frame.push_back(8'($urandom));
        frame[0]                  = {4'd4, 4'(oihl)};
        frame[IP_PROTO_OFS]       = PROTO_ICMP;
        frame[olen]               = kind;
        frame[olen + 1]           = code;
        frame[olen + 8]           = {4'd4, 4'(iihl)};
        frame[olen + 8 + 9]       = PROTO_UDP;
        frame[udp_at]             = src[15:8];
        frame[udp_at + 1]         = src[7:0];
        frame[udp_at + 2]         = dst[15:8];
        frame[udp_at + 3]         = dst[7:0];
    endtask

    task automatic build_noise(input int len, input logic [7:0] fill, input logic random_fill);
        frame.delete();
        for (int i = 0; i < len; i++)
            frame.push_back(random_fill ? 8'($urandom) : fill);
        if (random_fill && len > IP_PROTO_OFS && $urandom_range(3) == 0)
            frame[IP_PROTO_OFS] = PROTO_ICMP;
    endtask

    // Queue the first keep bytes of the frame, marking the final one
    task automatic send_frame(input int keep);
        for (int i = 0; i < keep; i++)
            packet_bytes.push_back('{data: frame[i], is_last: (i == keep - 1)});
    endtask

    task automatic random_packet();
        int oihl;
        int iihl;
        int keep;
        int r;
        logic [7:0]  kind;
        logic [7:0]  code;
        logic [15:0] src;
        logic [15:0] dst;
        if ($urandom_range(99) < 25)
        begin
            build_noise($urandom_range(1, 70), 8'h00, 1'b1);
            keep = frame.size();
        end
        else
        begin
            r = $urandom_range(99);
            oihl = (r < 80) ? 5 : (r < 90) ? $urandom_range(6, 15) : $urandom_range(0, 4);
            r = $urandom_range(99);
            iihl = (r < 80) ? 5 : (r < 92) ? $urandom_range(6, 15) : $urandom_range(0, 4);
            case ($urandom_range(5))
                0:
                begin
                    kind = ICMP_TIME_EXCEEDED;
                    code = CODE_TTL_EXPIRED;
                end
                1:
                begin
                    kind = ICMP_DEST_UNREACH;
                    code = CODE_PORT_UNREACH;
                end
                2:
                begin
                    kind = ICMP_DEST_UNREACH;
                    code = CODE_SRC_ROUTE;
                end
                3:
                begin
                    kind = ICMP_DEST_UNREACH;
                    code = 8'($urandom);
                end
                4:
                begin
                    kind = ICMP_TIME_EXCEEDED;
                    code = 8'($urandom);
                end
                default:
                begin
                    kind = 8'($urandom);
                    code = 8'($urandom);
                end
            endcase
            src = cfg_src_port;
            dst = cfg_dst_port;
            r = $urandom_range(99);
            if (r < 8)
                src = src ^ (16'd1 << $urandom_range(15));
            else if (r < 16)
                dst = dst ^ (16'd1 << $urandom_range(15));
            else if (r < 20)
                src = 16'($urandom);
            build_reply(oihl, iihl, kind, code, src, dst, $urandom_range(0, 20));
            // Break the protocol fields now and then
            if ($urandom_range(19) == 0)
                frame[IP_PROTO_OFS] = 8'($urandom_range(2, 255));
            if ($urandom_range(19) == 0)
                frame[oihl * 4 + 8 + 9] = 8'($urandom_range(0, 16));
            keep = ($urandom_range(99) < 88) ? frame.size() : $urandom_range(1, frame.size() - 1);
        end
        send_frame(keep);
        rand_bytes  = rand_bytes + keep;
        rand_frames = rand_frames + 1;
    endtask

    task automatic send_reply(input int oihl, input int iihl, input logic [7:0] kind,
                              input logic [7:0] code, input int pad);
        build_reply(oihl, iihl, kind, code, cfg_src_port, cfg_dst_port, pad);
        send_frame(frame.size());
    endtask

    // Wait until nothing is in flight, then let the pipeline settle
    task automatic wait_drained();
        do
        begin
            @(posedge clk);
            #1;
        end
        while (packet_bytes.size() != 0 || in_valid || pending_verdicts.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_port(input logic idx, input logic [15:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_SRC_PORT)
            cfg_src_port = value;
        else
            cfg_dst_port = value;
    endtask

    task automatic random_phase();
        int stop_at;
        stop_at = rand_bytes + PHASE_BYTES;
        while (rand_bytes < stop_at)
            random_packet();
    endtask

    initial
    begin : run
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed packets under the reset ports
        send_reply(5, 5, ICMP_TIME_EXCEEDED, CODE_TTL_EXPIRED, 0);
        send_reply(5, 5, ICMP_DEST_UNREACH, CODE_PORT_UNREACH, 0);
        send_reply(5, 5, ICMP_DEST_UNREACH, CODE_SRC_ROUTE, 0);
        send_reply(5, 5, ICMP_TIME_EXCEEDED, 8'd1, 0);
        send_reply(5, 5, ICMP_DEST_UNREACH, 8'd4, 3);
        send_reply(5, 5, 8'hFF, 8'hFF, 0);
        // Outer protocol not ICMP, embedded protocol not UDP
        build_reply(5, 5, ICMP_DEST_UNREACH, CODE_PORT_UNREACH, cfg_src_port, cfg_dst_port, 0);
        frame[IP_PROTO_OFS] = 8'd6;
        send_frame(frame.size());
        build_reply(5, 5, ICMP_DEST_UNREACH, CODE_PORT_UNREACH, cfg_src_port, cfg_dst_port, 0);
        frame[37] = 8'd6;
        send_frame(frame.size());
        // One port off by one
        build_reply(5, 5, ICMP_TIME_EXCEEDED, CODE_TTL_EXPIRED, cfg_src_port + 16'd1,
                    cfg_dst_port, 0);
        send_frame(frame.size());
        build_reply(5, 5, ICMP_TIME_EXCEEDED, CODE_TTL_EXPIRED, cfg_src_port,
                    cfg_dst_port - 16'd1, 0);
        send_frame(frame.size());
        // Outer header below 20, largest outer and embedded headers, overlapping ports
        send_reply(4, 5, ICMP_TIME_EXCEEDED, CODE_TTL_EXPIRED, 0);
        send_reply(15, 5, ICMP_DEST_UNREACH, CODE_PORT_UNREACH, 0);
        send_reply(5, 15, ICMP_DEST_UNREACH, CODE_SRC_ROUTE, 0);
        send_reply(5, 0, ICMP_TIME_EXCEEDED, CODE_TTL_EXPIRED, 0);
        send_reply(5, 2, ICMP_DEST_UNREACH, CODE_PORT_UNREACH, 0);
        // Short packets: one byte under the UDP port length bound, twice, and under its own header
        build_reply(5, 5, ICMP_TIME_EXCEEDED, CODE_TTL_EXPIRED, cfg_src_port, cfg_dst_port, 0);
        send_frame(frame.size() - 1);
        build_reply(5, 15, ICMP_TIME_EXCEEDED, CODE_TTL_EXPIRED, cfg_src_port, cfg_dst_port, 0);
        send_frame(frame.size() - 1);
        build_reply(15, 5, ICMP_DEST_UNREACH, CODE_PORT_UNREACH, cfg_src_port, cfg_dst_port, 0);
        send_frame(40);
        // Byte extremes, single-byte packets
        build_noise(1, 8'hFF, 1'b0);
        send_frame(1);
        build_noise(1, 8'h00, 1'b0);
        send_frame(1);
        build_noise(64, 8'hFF, 1'b0);
        send_frame(64);
        wait_drained();

        // Lowest ports
        write_port(CFG_SRC_PORT, 16'h0000);
        write_port(CFG_DST_PORT, 16'h0000);
        @(posedge clk);
        send_reply(5, 5, ICMP_TIME_EXCEEDED, CODE_TTL_EXPIRED, 0);
        random_phase();
        wait_drained();

        // Highest ports
        write_port(CFG_SRC_PORT, 16'hFFFF);
        write_port(CFG_DST_PORT, 16'hFFFF);
        @(posedge clk);
        send_reply(5, 5, ICMP_DEST_UNREACH, CODE_SRC_ROUTE, 0);
        random_phase();
        wait_drained();

        // No idling; the receiver holds off while the sender keeps offering
        write_port(CFG_SRC_PORT, 16'($urandom));
        write_port(CFG_DST_PORT, 16'($urandom));
        @(posedge clk);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        holds_asked   = holds_asked + 1;
        repeat (5)
            send_reply(5, 5, ICMP_DEST_UNREACH, CODE_PORT_UNREACH, 0);
        wait_drained();
        send_idle_pct = IDLE_PCT;
        recv_idle_pct = IDLE_PCT;

        // Random phases, new ports each time
        while (rand_bytes < RANDOM_BYTES || rand_frames < RANDOM_FRAMES)
        begin
            write_port(CFG_SRC_PORT, 16'($urandom));
            write_port(CFG_DST_PORT, ($urandom_range(3) == 0) ? 16'hFFFF : 16'($urandom));
            @(posedge clk);
            random_phase();
            wait_drained();
        end

        if (fail_count == 0)
            $display("icmp_error_udp_probe_classifier_top verification clean");
        else
            $display("icmp_error_udp_probe_classifier_top verification failed");
        $finish;
    end

    // Give up if the run hangs
    initial
    begin
        #(10_000_000);
        $display("icmp_error_udp_probe_classifier_top verification failed");
        $finish;
    end

endmodule

/* files.f */
sv/iepc_pkg.sv
sv/iepc_front.sv
sv/iepc_queue.sv
sv/iepc_back.sv
sv/icmp_error_udp_probe_classifier_top.sv
test/testbench.sv
